// ===== src/quaternion_to_rotation_matrix_macros.svh =====
// Assertion macros used by the quaternion to rotation matrix RTL
`ifndef QUATERNION_TO_ROTATION_MATRIX_MACROS_SVH
`define QUATERNION_TO_ROTATION_MATRIX_MACROS_SVH

// same-cycle implication
`define QRM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define QRM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/qrm_pkg.sv =====
// Types and constants of the quaternion to rotation matrix pipeline
`default_nettype none

package qrm_pkg;

   localparam int QW          = 16;              // Q2.14 element width
   localparam int LANES       = 9;               // matrix elements
   localparam int FRAC_SHIFT  = 14;
   localparam int PW          = 2 * QW;          // product width
   localparam int NW          = PW + 1;          // squared norm width
   localparam int SW          = PW + 2;          // signed numerator width
   localparam int MW          = PW + 1;          // numerator magnitude width
   localparam int RW          = MW + 2;          // divider remainder width
   localparam int QBITS       = QW + 1;          // quotient bits incl. rounding bit
   localparam int FRAC_BITS   = FRAC_SHIFT + 1;  // quotient bits below the binary point

   localparam int FRONT_DEPTH = 7;
   localparam int DIV_DEPTH   = QBITS + 1;
   localparam int OUT_DEPTH   = 2;
   localparam int STAGES      = FRONT_DEPTH + DIV_DEPTH + OUT_DEPTH;

   localparam int REQ_W       = 4 * QW;
   localparam int RSP_W       = LANES * QW;
   localparam int CSR_IW      = 2;

   localparam logic [NW-1:0]          UNIT_NORM = NW'(1) << (2 * FRAC_SHIFT);
   localparam logic [QW-1:0]          ELEM_ONE  = QW'(1) << FRAC_SHIFT;
   localparam logic [QW-1:0]          ELEM_MAX  = {1'b0, {(QW-1){1'b1}}};
   localparam logic [QW-1:0]          ELEM_MIN  = {1'b1, {(QW-1){1'b0}}};
   localparam logic [QBITS-1:0]       SAT_POS_Q = QBITS'(2 * (2**(QW-1) - 1) + 1);
   localparam logic [QBITS-1:0]       SAT_NEG_Q = QBITS'(2 * (2**(QW-1)) + 1);
   localparam logic [LANES-1:0]       DIAG_LANES = 9'b100_010_001;

   typedef enum logic [CSR_IW-1:0] {
      CSR_ZERO_THR = 2'd0,
      CSR_UNIT_THR = 2'd1
   } csr_index_type;

   typedef logic [STAGES-1:0] stage_vec_type;

   typedef struct packed {
      logic [LANES-1:0][MW-1:0] mag;
      logic [LANES-1:0]         neg;
      logic [NW-1:0]            den;
      logic                     ident;
   } div_in_type;

   typedef struct packed {
      logic [LANES-1:0][QBITS-1:0] quo;
      logic [LANES-1:0]            ovf;
      logic [LANES-1:0]            neg;
      logic                        ident;
   } div_out_type;

endpackage

`default_nettype wire

// ===== src/qrm_front.sv =====
// Front pipeline: products, norm, threshold tests, numerators and magnitudes
`default_nettype none

module qrm_front (
   input  logic                                 clock,
   input  logic [qrm_pkg::FRONT_DEPTH-1:0]      load,
   input  logic signed [qrm_pkg::QW-1:0]        quat_x,
   input  logic signed [qrm_pkg::QW-1:0]        quat_y,
   input  logic signed [qrm_pkg::QW-1:0]        quat_z,
   input  logic signed [qrm_pkg::QW-1:0]        quat_w,
   input  logic [qrm_pkg::QW-1:0]               zero_thr,
   input  logic [qrm_pkg::QW-1:0]               unit_thr,
   output qrm_pkg::div_in_type                  front_out
);
   import qrm_pkg::*;

   localparam int NX = NW + 1;
   localparam int TW = QW + FRAC_SHIFT;

   function automatic logic [SW-1:0] dbl_sum(input logic [PW-1:0] a,
                                              input logic [PW-1:0] b,
                                              input logic sub);
      logic [PW:0] ae;
      logic [PW:0] be;
      logic [PW:0] s;
      ae = {a[PW-1], a};
      be = {b[PW-1], b};
      s  = sub ? ae - be : ae + be;
      return {s, 1'b0};
   endfunction

   // stage 0
   logic signed [QW-1:0] x_ff, y_ff, z_ff, w_ff;
   // stage 1
   logic signed [PW-1:0] xx_ff, yy_ff, zz_ff, ww_ff;
   logic signed [PW-1:0] xy_ff, xz_ff, xw_ff, yz_ff, yw_ff, zw_ff;
   // stage 2..4: off-diagonal numerators 01, 02, 10, 12, 20, 21
   logic [5:0][SW-1:0]   off2_ff, off3_ff, off4_ff;
   logic [PW-1:0]        pxy2_ff, pzw2_ff, syz2_ff, sxz2_ff;
   logic [PW-1:0]        pxy3_ff, syz3_ff, sxz3_ff;
   logic [PW-1:0]        pxy4_ff, syz4_ff, sxz4_ff;
   logic [NW-1:0]        n3_ff, n4_ff;
   logic                 zero4_ff, unit4_ff;
   // stage 5
   logic [LANES-1:0][SW-1:0] num5_ff;
   logic [NW-1:0]            den5_ff;
   logic                     zero5_ff;
   // stage 6
   div_in_type               out_ff;

   // threshold tests
   logic [TW-1:0]  zero_lim;
   logic [NX-1:0]  unit_span;
   logic [NX-1:0]  n_plus;
   logic [NX-1:0]  unit_hi;
   logic           zero_hit;
   logic           unit_hit;

   assign zero_lim  = {zero_thr, {FRAC_SHIFT{1'b0}}};
   assign unit_span = NX'({unit_thr, {FRAC_SHIFT{1'b0}}});
   assign n_plus    = {1'b0, n3_ff} + unit_span;
   assign unit_hi   = NX'(UNIT_NORM) + unit_span;
   assign zero_hit  = n3_ff <= NW'(zero_lim);
   assign unit_hit  = (n_plus >= NX'(UNIT_NORM)) && ({1'b0, n3_ff} <= unit_hi);

   // divisor select and diagonal numerators
   logic [NW-1:0] den_sel;
   logic [SW:0]   d00, d11, d22;

   assign den_sel = unit4_ff ? UNIT_NORM : n4_ff;
   assign d00     = {2'b00, den_sel} - {2'b00, syz4_ff, 1'b0};
   assign d11     = {2'b00, den_sel} - {2'b00, sxz4_ff, 1'b0};
   assign d22     = {2'b00, den_sel} - {2'b00, pxy4_ff, 1'b0};

   // sign and magnitude
   logic [LANES-1:0][SW-1:0] num_neg;
   logic [LANES-1:0][MW-1:0] mag_sel;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         num_neg[l] = SW'(0) - num5_ff[l];
         mag_sel[l] = num5_ff[l][SW-1] ? num_neg[l][MW-1:0] : num5_ff[l][MW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         x_ff <= quat_x;
         y_ff <= quat_y;
         z_ff <= quat_z;
         w_ff <= quat_w;
      end
      if (load[1]) begin
         xx_ff <= PW'(x_ff) * PW'(x_ff);
         yy_ff <= PW'(y_ff) * PW'(y_ff);
         zz_ff <= PW'(z_ff) * PW'(z_ff);
         ww_ff <= PW'(w_ff) * PW'(w_ff);
         xy_ff <= PW'(x_ff) * PW'(y_ff);
         xz_ff <= PW'(x_ff) * PW'(z_ff);
         xw_ff <= PW'(x_ff) * PW'(w_ff);
         yz_ff <= PW'(y_ff) * PW'(z_ff);
         yw_ff <= PW'(y_ff) * PW'(w_ff);
         zw_ff <= PW'(z_ff) * PW'(w_ff);
      end
      if (load[2]) begin
         pxy2_ff    <= xx_ff + yy_ff;
         pzw2_ff    <= zz_ff + ww_ff;
         syz2_ff    <= yy_ff + zz_ff;
         sxz2_ff    <= xx_ff + zz_ff;
         off2_ff[0] <= dbl_sum(xy_ff, zw_ff, 1'b1);
         off2_ff[1] <= dbl_sum(xz_ff, yw_ff, 1'b0);
         off2_ff[2] <= dbl_sum(xy_ff, zw_ff, 1'b0);
         off2_ff[3] <= dbl_sum(yz_ff, xw_ff, 1'b1);
         off2_ff[4] <= dbl_sum(xz_ff, yw_ff, 1'b1);
         off2_ff[5] <= dbl_sum(yz_ff, xw_ff, 1'b0);
      end
      if (load[3]) begin
         n3_ff   <= {1'b0, pxy2_ff} + {1'b0, pzw2_ff};
         pxy3_ff <= pxy2_ff;
         syz3_ff <= syz2_ff;
         sxz3_ff <= sxz2_ff;
         off3_ff <= off2_ff;
      end
      if (load[4]) begin
         zero4_ff <= zero_hit;
         unit4_ff <= unit_hit;
         n4_ff    <= n3_ff;
         pxy4_ff  <= pxy3_ff;
         syz4_ff  <= syz3_ff;
         sxz4_ff  <= sxz3_ff;
         off4_ff  <= off3_ff;
      end
      if (load[5]) begin
         den5_ff    <= den_sel;
         zero5_ff   <= zero4_ff;
         num5_ff[0] <= d00[SW-1:0];
         num5_ff[1] <= off4_ff[0];
         num5_ff[2] <= off4_ff[1];
         num5_ff[3] <= off4_ff[2];
         num5_ff[4] <= d11[SW-1:0];
         num5_ff[5] <= off4_ff[3];
         num5_ff[6] <= off4_ff[4];
         num5_ff[7] <= off4_ff[5];
         num5_ff[8] <= d22[SW-1:0];
      end
      if (load[6]) begin
         for (int l = 0; l < LANES; l++) begin
            out_ff.mag[l] <= mag_sel[l];
            out_ff.neg[l] <= num5_ff[l][SW-1];
         end
         out_ff.den   <= den5_ff;
         out_ff.ident <= zero5_ff;
      end
   end

   assign front_out = out_ff;

endmodule

`default_nettype wire

// ===== src/qrm_div.sv =====
// Pipelined restoring divider, nine lanes sharing one divisor, one quotient bit per stage
`default_nettype none

module qrm_div (
   input  logic                             clock,
   input  logic [qrm_pkg::DIV_DEPTH-1:0]    load,
   input  qrm_pkg::div_in_type              div_in,
   output qrm_pkg::div_out_type             div_out
);
   import qrm_pkg::*;

   logic [LANES-1:0][RW-1:0]    rem_ff   [DIV_DEPTH];
   logic [LANES-1:0][QBITS-1:0] quo_ff   [DIV_DEPTH];
   logic [LANES-1:0]            ovf_ff   [DIV_DEPTH];
   logic [LANES-1:0]            neg_ff   [DIV_DEPTH];
   logic                        ident_ff [DIV_DEPTH];
   logic [NW-1:0]               den_ff   [DIV_DEPTH];

   // stage 0: quotient at or above 2^QBITS saturates
   logic [LANES-1:0] ovf_hit;
   logic [RW-1:0]    den_x4;

   assign den_x4 = {div_in.den, 2'b00};

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         ovf_hit[l] = {2'b00, div_in.mag[l]} >= den_x4;
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         for (int l = 0; l < LANES; l++) begin
            rem_ff[0][l] <= RW'(div_in.mag[l]);
            quo_ff[0][l] <= '0;
         end
         ovf_ff[0]   <= ovf_hit;
         neg_ff[0]   <= div_in.neg;
         ident_ff[0] <= div_in.ident;
         den_ff[0]   <= div_in.den;
      end
   end

   for (genvar j = 1; j < DIV_DEPTH; j++) begin : g_step
      localparam int BIT = QBITS - j;

      logic [LANES-1:0][RW-1:0] r_cmp;
      logic [RW-1:0]            d_cmp;
      logic [LANES-1:0][RW:0]   diff;
      logic [LANES-1:0]         take;

      if (BIT >= FRAC_BITS) begin : g_int
         assign d_cmp = RW'(den_ff[j-1]) << (BIT - FRAC_BITS);
         assign r_cmp = rem_ff[j-1];
      end else begin : g_frac
         assign d_cmp = RW'(den_ff[j-1]);
         always_comb begin
            for (int l = 0; l < LANES; l++) begin
               r_cmp[l] = {rem_ff[j-1][l][RW-2:0], 1'b0};
            end
         end
      end

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            diff[l] = {1'b0, r_cmp[l]} - {1'b0, d_cmp};
            take[l] = ~diff[l][RW];
         end
      end

      always_ff @(posedge clock) begin
         if (load[j]) begin
            for (int l = 0; l < LANES; l++) begin
               rem_ff[j][l] <= take[l] ? diff[l][RW-1:0] : r_cmp[l];
               quo_ff[j][l] <= quo_ff[j-1][l] | (QBITS'(take[l]) << BIT);
            end
            ovf_ff[j]   <= ovf_ff[j-1];
            neg_ff[j]   <= neg_ff[j-1];
            ident_ff[j] <= ident_ff[j-1];
            den_ff[j]   <= den_ff[j-1];
         end
      end
   end

   assign div_out.quo   = quo_ff[DIV_DEPTH-1];
   assign div_out.ovf   = ovf_ff[DIV_DEPTH-1];
   assign div_out.neg   = neg_ff[DIV_DEPTH-1];
   assign div_out.ident = ident_ff[DIV_DEPTH-1];

endmodule

`default_nettype wire

// ===== src/qrm_out.sv =====
// Output stages: round half away from zero, saturate, apply sign and identity
`default_nettype none

module qrm_out (
   input  logic                                      clock,
   input  logic [qrm_pkg::OUT_DEPTH-1:0]             load,
   input  qrm_pkg::div_out_type                      div_out,
   output logic [qrm_pkg::LANES-1:0][qrm_pkg::QW-1:0] elem,
   output logic                                      ident
);
   import qrm_pkg::*;

   // stage 0
   logic [LANES-1:0][QBITS-1:0] rnd_ff;
   logic [LANES-1:0]            sat_ff;
   logic [LANES-1:0]            neg_ff;
   logic                        ident0_ff;
   // stage 1
   logic [LANES-1:0][QW-1:0]    elem_ff;
   logic                        ident_ff;

   logic [LANES-1:0][QBITS:0]   inc;
   logic [LANES-1:0]            sat_hit;
   logic [LANES-1:0][QBITS-1:0] rnd_neg;
   logic [LANES-1:0][QW-1:0]    val;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         inc[l]     = {1'b0, div_out.quo[l]} + (QBITS+1)'(1);
         sat_hit[l] = div_out.ovf[l] ||
                      (div_out.neg[l] ? (div_out.quo[l] >= SAT_NEG_Q)
                                      : (div_out.quo[l] >= SAT_POS_Q));
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         rnd_neg[l] = QBITS'(0) - rnd_ff[l];
         if (ident0_ff) begin
            val[l] = DIAG_LANES[l] ? ELEM_ONE : '0;
         end else if (sat_ff[l]) begin
            val[l] = neg_ff[l] ? ELEM_MIN : ELEM_MAX;
         end else begin
            val[l] = neg_ff[l] ? rnd_neg[l][QW-1:0] : rnd_ff[l][QW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         for (int l = 0; l < LANES; l++) begin
            rnd_ff[l] <= inc[l][QBITS:1];
         end
         sat_ff    <= sat_hit;
         neg_ff    <= div_out.neg;
         ident0_ff <= div_out.ident;
      end
      if (load[1]) begin
         elem_ff  <= val;
         ident_ff <= ident0_ff;
      end
   end

   assign elem  = elem_ff;
   assign ident = ident_ff;

endmodule

`default_nettype wire

// ===== src/quaternion_to_rotation_matrix.sv =====
// Quaternion to 3x3 rotation matrix, Q2.14, fully pipelined
//
// Requests arrive on req_ (tvalid/tready/tdata, x y z w from bit 0 up) and each
// produces exactly one result on rsp_: nine Q2.14 elements in tdata, row-major
// from bit 0 up, and the identity flag in tuser. Thresholds are written on the
// csr_ port (index 0 zero threshold, index 1 unit threshold) while idle.
// The request path has 27 register stages: 7 front, 18 divider, 2 output.
// Throughput is one request per cycle while rsp_tready is high or a stage is
// empty; the 17-bit quotient is produced by a restoring divider unrolled into
// one stage per bit, shared by all nine elements.
// Each stage holds a valid bit; a stage loads whenever it or any later stage
// holds a bubble, so req_tready stays high while any stage is empty even when
// the result register is stalled by rsp_tready low. Nothing is dropped or
// repeated under a stall.
// Reset (synchronous) clears all valid bits and sets both thresholds to 1 (one LSB).
`default_nettype none

`include "quaternion_to_rotation_matrix_macros.svh"

module quaternion_to_rotation_matrix (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [qrm_pkg::REQ_W-1:0]     req_tdata,   // quat_x, quat_y, quat_z, quat_w
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [qrm_pkg::RSP_W-1:0]     rsp_tdata,   // elem_00 .. elem_22, row-major
   output logic                          rsp_tuser,   // identity_used
   input  logic                          csr_we,
   input  logic [qrm_pkg::CSR_IW-1:0]    csr_index,
   input  logic [qrm_pkg::QW-1:0]        csr_wdata
);
   import qrm_pkg::*;

   localparam stage_vec_type ALL_VALID = '1;
   localparam int            DIV_BASE  = FRONT_DEPTH;
   localparam int            OUT_BASE  = FRONT_DEPTH + DIV_DEPTH;

   logic [QW-1:0]  zero_thr_ff;
   logic [QW-1:0]  unit_thr_ff;
   stage_vec_type  valid_ff;
   stage_vec_type  valid_in;
   stage_vec_type  ready;

   div_in_type               front_out;
   div_out_type              div_out;
   logic [LANES-1:0][QW-1:0] elem;
   logic                     ident;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         zero_thr_ff <= QW'(1);
         unit_thr_ff <= QW'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ZERO_THR: zero_thr_ff <= csr_wdata;
            CSR_UNIT_THR: unit_thr_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // a stage may load when it or any later stage is empty, or the output drains
   for (genvar k = 0; k < STAGES; k++) begin : g_ready
      localparam stage_vec_type LOW_MASK = ~(ALL_VALID << k);
      assign ready[k] = rsp_tready || ((valid_ff | LOW_MASK) != ALL_VALID);
   end

   assign valid_in = (ready & {valid_ff[STAGES-2:0], req_tvalid}) | (~ready & valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = ready[0];
   assign rsp_tvalid = valid_ff[STAGES-1];

   qrm_front u_front (
      .clock     (clock),
      .load      (ready[FRONT_DEPTH-1:0]),
      .quat_x    ($signed(req_tdata[QW-1:0])),
      .quat_y    ($signed(req_tdata[2*QW-1:QW])),
      .quat_z    ($signed(req_tdata[3*QW-1:2*QW])),
      .quat_w    ($signed(req_tdata[4*QW-1:3*QW])),
      .zero_thr  (zero_thr_ff),
      .unit_thr  (unit_thr_ff),
      .front_out (front_out)
   );

   qrm_div u_div (
      .clock   (clock),
      .load    (ready[DIV_BASE +: DIV_DEPTH]),
      .div_in  (front_out),
      .div_out (div_out)
   );

   qrm_out u_out (
      .clock   (clock),
      .load    (ready[OUT_BASE +: OUT_DEPTH]),
      .div_out (div_out),
      .elem    (elem),
      .ident   (ident)
   );

   assign rsp_tdata = elem;
   assign rsp_tuser = ident;

   `QRM_ASSERT_NOW(a_bubble_accepts, clock, reset, valid_ff != ALL_VALID, req_tready, "pipeline has a bubble but refuses a request")
   `QRM_ASSERT_NEXT(a_stall_keeps, clock, reset, rsp_tvalid && !rsp_tready && valid_ff[STAGES-2], valid_ff[STAGES-2] && rsp_tvalid, "stalled item lost from pipeline")
   `QRM_ASSERT_NOW(a_ident_matrix, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[QW-1:0] == ELEM_ONE && rsp_tdata[5*QW-1:4*QW] == ELEM_ONE && rsp_tdata[9*QW-1:8*QW] == ELEM_ONE && rsp_tdata[2*QW-1:QW] == '0, "identity result malformed")
   `QRM_ASSERT_NEXT(a_csr_write, clock, reset, csr_we && csr_index == CSR_UNIT_THR, unit_thr_ff == $past(csr_wdata), "unit threshold write not taken")

endmodule

`default_nettype wire
